// ===== rtl/stme_pkg.sv =====
// shared constants, codes and control types of the sparse tile map run encoder
// no dependencies; imported by the datapath, the controller, the top level and the testbench
package stme_pkg;

    // map geometry
    localparam int MAP_WIDTH   = 20;
    localparam int MAP_HEIGHT  = 18;
    localparam int LINE_STRIDE = 32;

    // derived widths
    localparam int LEN_W   = $clog2(MAP_WIDTH + 1);
    localparam int IDX_W   = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int ROW_W   = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
    localparam int POS_W   = $clog2((MAP_HEIGHT - 1) * LINE_STRIDE + MAP_WIDTH + 1);
    localparam int DELTA_W = 16;
    localparam int CELL_W  = 16;
    localparam int BYTE_W  = 8;

    // output byte select codes
    localparam logic [2:0] SEL_LEN  = 3'd0;
    localparam logic [2:0] SEL_DLO  = 3'd1;
    localparam logic [2:0] SEL_DHI  = 3'd2;
    localparam logic [2:0] SEL_DATA = 3'd3;
    localparam logic [2:0] SEL_END  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       load;
        logic [2:0] sel;
        logic       last;
    } stme_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic acc_flush;
        logic acc_frame_end;
        logic data_last;
        logic pend_frame_end;
        logic out_free;
    } stme_sts_t;

endpackage

// ===== rtl/stme_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module stme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/stme_datapath.sv =====
// datapath: position counters, run buffer, header latch and output byte register
// depends on stme_pkg and stme_ram
module stme_datapath
    import stme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              mode,
    input  logic [CELL_W-1:0] cell_in,
    input  stme_cmd_t         cmd,
    output stme_sts_t         sts,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last
);

    logic [LEN_W-1:0]   run_len_reg, run_len_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [POS_W-1:0]   row_base_reg, row_base_next;
    logic [POS_W-1:0]   prev_end_reg, prev_end_next;
    logic [POS_W-1:0]   run_start_reg;
    logic [LEN_W-1:0]   flen_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic               fend_reg;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;

    logic               transp;
    logic               row_end;
    logic               frame_end;
    logic               flush;
    logic [LEN_W-1:0]   new_len;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   flush_start;
    logic [DELTA_W-1:0] delta;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  rd_data;
    logic [BYTE_W-1:0]  byte_mux;
    logic               ram_we;

    assign transp      = (cell_in[7:0] == 8'd0);
    assign row_end     = (col_reg == IDX_W'(MAP_WIDTH - 1));
    assign frame_end   = row_end && (row_reg == ROW_W'(MAP_HEIGHT - 1));
    assign new_len     = transp ? run_len_reg : run_len_reg + LEN_W'(1);
    assign flush       = transp ? (run_len_reg != '0) : row_end;
    assign cur_pos     = row_base_reg + POS_W'(col_reg);
    assign flush_start = (run_len_reg == '0) ? cur_pos : run_start_reg;
    assign delta       = DELTA_W'(flush_start) - DELTA_W'(prev_end_reg);
    assign data_byte   = mode ? cell_in[15:8] : (cell_in[7:0] - 8'd1);
    assign ram_we      = cmd.accept && !transp;

    // run data bytes, read one ahead so the data phase streams
    stme_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_WIDTH)
    ) u_run_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (run_len_reg[IDX_W-1:0]),
        .wdata (data_byte),
        .raddr (rd_idx_next),
        .rdata (rd_data)
    );

    always_comb begin
        run_len_next  = run_len_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        prev_end_next = prev_end_reg;
        if (cmd.accept) begin
            run_len_next = flush ? '0 : new_len;
            if (flush) begin
                prev_end_next = flush_start + POS_W'(new_len);
            end
            if (row_end) begin
                col_next = '0;
                if (frame_end) begin
                    row_next      = '0;
                    row_base_next = '0;
                    prev_end_next = '0;
                end else begin
                    row_next      = row_reg + ROW_W'(1);
                    row_base_next = row_base_reg + POS_W'(LINE_STRIDE);
                end
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.accept) begin
            rd_idx_next = '0;
        end else if (cmd.load && (cmd.sel == SEL_DATA) && !sts.data_last) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        case (cmd.sel)
            SEL_LEN:  byte_mux = BYTE_W'(flen_reg);
            SEL_DLO:  byte_mux = delta_reg[7:0];
            SEL_DHI:  byte_mux = delta_reg[15:8];
            SEL_DATA: byte_mux = rd_data;
            SEL_END:  byte_mux = 8'd0;
            default:  byte_mux = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg   <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            prev_end_reg  <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            run_len_reg  <= run_len_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            prev_end_reg <= prev_end_next;
            rd_idx_reg   <= rd_idx_next;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (!transp && (run_len_reg == '0)) begin
                run_start_reg <= cur_pos;
            end
            if (flush) begin
                flen_reg  <= new_len;
                delta_reg <= delta;
            end
            fend_reg <= frame_end;
        end
        if (cmd.load) begin
            out_byte_reg <= byte_mux;
            out_last_reg <= cmd.last;
        end
    end

    assign sts.acc_flush      = flush;
    assign sts.acc_frame_end  = frame_end;
    assign sts.data_last      = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == flen_reg);
    assign sts.pend_frame_end = fend_reg;
    assign sts.out_free       = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    // an open run never reaches a full row, the row end always closes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_len_reg <= LEN_W'(MAP_WIDTH - 1))
        else $error("open run length out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= IDX_W'(MAP_WIDTH - 1))
        else $error("column out of range");

    // the frame end returns every position counter to the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && frame_end |=> (row_reg == '0) && (col_reg == '0)
            && (prev_end_reg == '0) && (row_base_reg == '0))
        else $error("position not cleared at frame end");
`endif

endmodule

// ===== rtl/stme_ctrl.sv =====
// controller: steps through count, delta and data bytes of a closed run and the end mark
// depends on stme_pkg
module stme_ctrl
    import stme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  stme_sts_t sts,
    output stme_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_DLO  = 3'd2;
    localparam logic [2:0] ST_DHI  = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_END  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.sel    = SEL_LEN;
        cmd.last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = in_valid;
                if (in_valid) begin
                    if (sts.acc_flush) begin
                        state_next = ST_LEN;
                    end else if (sts.acc_frame_end) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_LEN: begin
                cmd.load = sts.out_free;
                cmd.sel  = SEL_LEN;
                if (sts.out_free) begin
                    state_next = ST_DLO;
                end
            end
            ST_DLO: begin
                cmd.load = sts.out_free;
                cmd.sel  = SEL_DLO;
                if (sts.out_free) begin
                    state_next = ST_DHI;
                end
            end
            ST_DHI: begin
                cmd.load = sts.out_free;
                cmd.sel  = SEL_DHI;
                if (sts.out_free) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                cmd.load = sts.out_free;
                cmd.sel  = SEL_DATA;
                cmd.last = sts.data_last && !sts.pend_frame_end;
                if (sts.out_free && sts.data_last) begin
                    state_next = sts.pend_frame_end ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                cmd.load = sts.out_free;
                cmd.sel  = SEL_END;
                cmd.last = 1'b1;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a byte is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> sts.out_free)
        else $error("output register overwritten");

    // a cell that closes a run starts with the count byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && sts.acc_flush |=> state_reg == ST_LEN)
        else $error("closed run not emitted");

    // no new cell while bytes of the previous one are pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !cmd.load)
        else $error("cell accepted during emission");
`endif

endmodule

// ===== rtl/sparse_tile_map_run_encoder.sv =====
// top level of the sparse tile map run encoder: stream ports, register port, hookup
// depends on stme_pkg, stme_ctrl and stme_datapath
//
// Cells of a MAP_WIDTH x MAP_HEIGHT tile map enter in raster order, one 16-bit cell
// per input word (tile number in the low byte, attributes in the high byte; a zero
// tile number is transparent). Every run of non-transparent cells in a row comes out
// as a byte stream: the run length, a 16-bit delta low byte first from the end of the
// previous run to the run start (positions are row * LINE_STRIDE + column), then one
// data byte per cell, the tile number minus one or, with attribute_mode set, the
// attribute byte. The mode is sampled as each cell arrives. After the last cell of a
// frame a zero end byte follows and the position returns to the origin. m_tlast marks
// the final byte caused by one input cell; a cell that closes no run and ends no
// frame produces nothing. Bytes leave through a single output register at one per
// cycle while m_tready is high; the next cell is accepted while the last byte still
// waits in that register. attribute_mode is register 0 at byte address 0 and is to
// be written only while idle by the user; the block itself does not enforce this.
module sparse_tile_map_run_encoder
    import stme_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // input cells
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] cell_value

    // output bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last_of_item

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register index decode: index is paddr[2], only index 0 exists
    localparam logic REG_ATTR_MODE = 1'b0;

    logic      mode_reg;
    logic      cfg_write;
    stme_cmd_t cmd;
    stme_sts_t sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_write && (paddr[2] == REG_ATTR_MODE)) begin
            mode_reg <= pwdata[0];
        end
    end

    // read back; the other address reads as zero
    assign prdata = (paddr[2] == REG_ATTR_MODE) ? {31'd0, mode_reg} : 32'd0;

    // sequencer for the byte groups
    stme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // counters, run buffer and output register
    stme_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .cell_in   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== dv/sparse_tile_map_run_encoder_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the sparse tile map run encoder: stream and register drivers,
// a run predictor with a byte scoreboard; depends on stme_pkg and the encoder rtl
module sparse_tile_map_run_encoder_tb;
    import stme_pkg::*;

    // register byte addresses: attribute_mode and one unmapped slot
    localparam logic [2:0] ADDR_ATTR_MODE = 3'd0;
    localparam logic [2:0] ADDR_SPARE     = 3'd4;

    // cycles allowed after the last expected word for a silent cell still in flight
    localparam int SETTLE_CYCLES = 8;
    // cycles with no handshake on any port before the run is declared hung
    localparam int STUCK_LIMIT   = 500;
    // random rows after the directed row: completes one whole frame
    localparam int RANDOM_ROWS   = MAP_HEIGHT - 1;

    typedef enum int {ROW_DENSE, ROW_SPARSE, ROW_FULL, ROW_EMPTY, ROW_SPAN} row_style_t;

    // predicts the packed byte stream of every accepted cell and checks the words that leave
    class run_scoreboard;
        logic        attr_mode = 1'b0;
        logic [7:0]  run_data [MAP_WIDTH];
        int unsigned run_len = 0;
        int unsigned col = 0;
        int unsigned row_idx = 0;
        logic [15:0] prev_end = 16'd0;
        logic [7:0]  burst [$];
        logic [7:0]  exp_byte [$];
        logic        exp_last [$];
        int          errors = 0;
        int          checked = 0;
        int          cells = 0;
        int          runs = 0;
        int          frames = 0;

        function void report(input string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void write_reg(input logic [2:0] addr, input logic [31:0] value);
            if (addr == ADDR_ATTR_MODE)
                attr_mode = value[0];
        endfunction

        // count, delta low, delta high, then the held data bytes
        function void close_run(input int unsigned end_col);
            logic [15:0] start;
            logic [15:0] delta;
            if (run_len == 0)
                return;
            start = 16'(row_idx * LINE_STRIDE + end_col - run_len);
            delta = start - prev_end;
            burst.push_back(8'(run_len));
            burst.push_back(delta[7:0]);
            burst.push_back(delta[15:8]);
            for (int k = 0; k < run_len; k++)
                burst.push_back(run_data[k]);
            prev_end = start + 16'(run_len);
            run_len = 0;
            runs++;
        endfunction

        function void note_cell(input logic [15:0] cell_word);
            if (cell_word[7:0] == 8'h00) begin
                close_run(col);
            end else if (run_len < MAP_WIDTH) begin
                // data byte takes the mode in force when the cell arrives
                run_data[run_len] = attr_mode ? cell_word[15:8] : cell_word[7:0] - 8'd1;
                run_len++;
            end
            col++;
            if (col >= MAP_WIDTH) begin
                close_run(MAP_WIDTH);
                col = 0;
                row_idx++;
                if (row_idx >= MAP_HEIGHT) begin
                    burst.push_back(8'h00);
                    row_idx = 0;
                    prev_end = 16'd0;
                    frames++;
                end
            end
            foreach (burst[i]) begin
                exp_byte.push_back(burst[i]);
                exp_last.push_back(i == burst.size() - 1);
            end
            burst.delete();
            cells++;
        endfunction

        function void check_word(input logic [7:0] got_byte, input logic got_last);
            logic [7:0] want_byte;
            logic       want_last;
            if (exp_byte.size() == 0) begin
                report($sformatf("word %02h last %0b with nothing expected", got_byte, got_last));
                return;
            end
            want_byte = exp_byte.pop_front();
            want_last = exp_last.pop_front();
            if (got_byte !== want_byte || got_last !== want_last)
                report($sformatf("word %0d: expected %02h last %0b, got %02h last %0b",
                                 checked, want_byte, want_last, got_byte, got_last));
            checked++;
        endfunction

        function int pending();
            return exp_byte.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    run_scoreboard sb;
    int            idle_odds = 0;   // percent chance of an idle burst, both sides
    int            stall_left = 0;
    int            stuck = 0;

    always #5 aclk = ~aclk;

    sparse_tile_map_run_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] cell_value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tlast  (m_tlast),    // last_of_item
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // receiver backpressure: random bursts of stalled cycles, started with idle_odds percent chance
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= idle_odds) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // every word leaving the block is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast);
    end

    // hang detection: no handshake on any port for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("timeout after %0d idle cycles", stuck);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one cell, optionally after a sender gap; tvalid stays high afterwards
    task automatic send_cell(input logic [15:0] cell_word);
        int gap;
        if ($urandom_range(1, 100) <= idle_odds) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cell_word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_cell(cell_word);
    endtask

    // stop sending and let every predicted word come out, plus SETTLE_CYCLES for a
    // cell that produced nothing but may still be inside
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // read attribute_mode back and compare with the predicted value
    task automatic reg_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ATTR_MODE;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {31'd0, sb.attr_mode})
            sb.report($sformatf("attribute_mode read %08h, expected %0b", prdata, sb.attr_mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] opaque_cell();
        logic [15:0] cell_word;
        cell_word = 16'($urandom);
        if (cell_word[7:0] == 8'h00)
            cell_word[7:0] = 8'($urandom_range(1, 255));
        return cell_word;
    endfunction

    function automatic logic [15:0] clear_cell();
        return {8'($urandom), 8'h00};
    endfunction

    // one map row in a given shape; flip_at >= 0 toggles the mode at that column
    // after the block has gone idle, so an open run mixes both data byte forms
    task automatic send_row(input row_style_t style, input int flip_at);
        int span_lo;
        int span_hi;
        bit opaque;
        span_lo = $urandom_range(0, MAP_WIDTH - 1);
        span_hi = $urandom_range(span_lo, MAP_WIDTH - 1);
        for (int c = 0; c < MAP_WIDTH; c++) begin
            if (c == flip_at) begin
                drain();
                reg_write(ADDR_ATTR_MODE, {31'($urandom), ~sb.attr_mode});
            end
            case (style)
                ROW_DENSE:  opaque = ($urandom_range(0, 3) != 0);
                ROW_SPARSE: opaque = ($urandom_range(0, 3) == 0);
                ROW_FULL:   opaque = 1'b1;
                ROW_EMPTY:  opaque = 1'b0;
                default:    opaque = (c >= span_lo && c <= span_hi);
            endcase
            send_cell(opaque ? opaque_cell() : clear_cell());
        end
    endtask

    initial begin
        row_style_t style;
        int         flip_at;
        sb = new;

        // reset held from the start, released once
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mode resets to zero; write the reset value explicitly as well
        reg_check();
        reg_write(ADDR_ATTR_MODE, 32'h0);

        // directed first row, twenty cells
        idle_odds = 20;
        send_cell(16'h0001);    // smallest tile, data byte zero
        send_cell(16'hFFFF);    // every bit set
        send_cell(16'h00FF);    // largest tile, no attributes
        send_cell(16'hA5C3);
        send_cell(16'h0000);    // closes a four-cell run at the origin, zero delta
        send_cell(16'hFF00);    // transparent with attributes, nothing open
        send_cell(16'h1280);
        // mode switch in the middle of an open run
        drain();
        reg_write(ADDR_ATTR_MODE, 32'h1);
        reg_check();
        send_cell(16'h7E01);
        send_cell(16'h80FE);
        send_cell(16'h5A00);    // closes the mixed-mode run
        repeat (10) send_cell(opaque_cell());  // run closed by the row end
        drain();

        // unmapped address is ignored, only bit 0 of the data counts
        reg_write(ADDR_SPARE, 32'h0);
        reg_check();
        reg_write(ADDR_ATTR_MODE, 32'hFFFF_FFFE);
        reg_check();

        // random rows; the last row of each frame ends in a run to exercise the
        // end mark, and the very last row is fully opaque for the longest burst
        for (int r = 1; r <= RANDOM_ROWS; r++) begin
            if (r % 6 == 0) begin
                drain();
                reg_write(ADDR_ATTR_MODE, 32'($urandom));
                reg_check();
            end
            idle_odds = ((r >= 12 && r <= 15) || r > RANDOM_ROWS - 4) ? 0 : 20;
            if (r == RANDOM_ROWS)
                style = ROW_FULL;
            else if (r % MAP_HEIGHT == MAP_HEIGHT - 1)
                style = $urandom_range(0, 1) ? ROW_FULL : ROW_DENSE;
            else
                style = row_style_t'($urandom_range(0, 4));
            flip_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAP_WIDTH - 1) : -1;
            send_row(style, flip_at);
        end

        drain();
        repeat (20) @(posedge aclk);

        $display("encoded %0d cells over %0d frame ends: %0d runs, %0d words checked",
                 sb.cells, sb.frames, sb.runs, sb.checked);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/stme_pkg.sv
rtl/stme_ram.sv
rtl/stme_datapath.sv
rtl/stme_ctrl.sv
rtl/sparse_tile_map_run_encoder.sv
dv/sparse_tile_map_run_encoder_tb.sv
